>>> hdl/apc_pkg.sv
`timescale 1ns / 1ps
// Package of the Armenteros-Podolanski calculator.
// Holds the flag group that travels beside the divider and root stages.
package apc_pkg;

  // Per-candidate flags carried down the pipeline.
  typedef struct packed {
    logic neg;      // alpha is negative
    logic ovf;      // alpha quotient beyond the quotient width
    logic deg_mo;   // mother vector is zero
    logic deg_den;  // alpha denominator is zero
  } apc_flags_t;

  localparam int FlagBits = $bits(apc_flags_t);

endpackage

>>> hdl/apc_cand_if.sv
`timescale 1ns / 1ps
// Candidate channel: valid/ready handshake with the decay momenta.
// Depends on nothing else.
interface apc_cand_if #(
  parameter int MOMENTUM_BITS = 24
);
  logic valid;
  logic ready;
  logic signed [MOMENTUM_BITS-1:0] mother_px;
  logic signed [MOMENTUM_BITS-1:0] mother_py;
  logic signed [MOMENTUM_BITS-1:0] mother_pz;
  logic signed [MOMENTUM_BITS-1:0] first_px;
  logic signed [MOMENTUM_BITS-1:0] first_py;
  logic signed [MOMENTUM_BITS-1:0] first_pz;
  logic signed [MOMENTUM_BITS-1:0] second_px;
  logic signed [MOMENTUM_BITS-1:0] second_py;
  logic signed [MOMENTUM_BITS-1:0] second_pz;
  logic first_is_positive;

  modport source (
    output valid, mother_px, mother_py, mother_pz, first_px, first_py, first_pz,
           second_px, second_py, second_pz, first_is_positive,
    input  ready
  );
  modport sink (
    input  valid, mother_px, mother_py, mother_pz, first_px, first_py, first_pz,
           second_px, second_py, second_pz, first_is_positive,
    output ready
  );
endinterface

>>> hdl/apc_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with transverse momentum and alpha.
// Depends on nothing else.
interface apc_res_if #(
  parameter int MOMENTUM_BITS   = 24,
  parameter int ALPHA_FRAC_BITS = 14
);
  logic valid;
  logic ready;
  logic [MOMENTUM_BITS-1:0]          transverse_momentum;
  logic signed [ALPHA_FRAC_BITS+1:0] asymmetry;
  logic                              asymmetry_saturated;
  logic                              degenerate;

  modport source (
    output valid, transverse_momentum, asymmetry, asymmetry_saturated, degenerate,
    input  ready
  );
  modport sink (
    input  valid, transverse_momentum, asymmetry, asymmetry_saturated, degenerate,
    output ready
  );
endinterface

>>> hdl/armenteros_podolanski_calc.sv
`timescale 1ns / 1ps
// Armenteros-Podolanski calculator: transverse momentum and alpha per candidate.
// The pipeline has seven product and sum stages, one stage per alpha quotient bit,
// one per transverse quotient bit, one per root bit and the output register.
// Throughput is one candidate per cycle; the whole pipeline holds while a result waits.
// Reset is synchronous and clears only the valid bits.
module armenteros_podolanski_calc #(
  parameter int MOMENTUM_BITS   = 24,
  parameter int ALPHA_FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst,
  apc_cand_if.sink   cand,
  apc_res_if.source  res
);
  import apc_pkg::*;

  localparam int MB  = MOMENTUM_BITS;
  localparam int F   = ALPHA_FRAC_BITS;
  localparam int P2  = 2 * MB;
  localparam int P4  = 4 * MB;
  localparam int QA  = F + 2;
  localparam int NA  = P2 + F + 4;
  localparam int DWA = P2 + 4;
  localparam int AW  = F + 2;
  localparam int TWA = P4 + P2 + FlagBits;
  localparam int TWP = QA + FlagBits;

  logic en;
  logic [7:1] v;

  // The pipeline moves unless a result is waiting untaken.
  assign en         = !res.valid || res.ready;
  assign cand.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:1], cand.valid};
    end
  end

  // Stage 1: register the vectors, with the daughters put in charge order.
  logic signed [MB-1:0] mo1 [3];
  logic signed [MB-1:0] pp1 [3];
  logic signed [MB-1:0] pm1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      mo1[0] <= cand.mother_px;
      mo1[1] <= cand.mother_py;
      mo1[2] <= cand.mother_pz;
      pp1[0] <= cand.first_is_positive ? cand.first_px : cand.second_px;
      pp1[1] <= cand.first_is_positive ? cand.first_py : cand.second_py;
      pp1[2] <= cand.first_is_positive ? cand.first_pz : cand.second_pz;
      pm1[0] <= cand.first_is_positive ? cand.second_px : cand.first_px;
      pm1[1] <= cand.first_is_positive ? cand.second_py : cand.first_py;
      pm1[2] <= cand.first_is_positive ? cand.second_pz : cand.first_pz;
    end
  end

  // Stage 2: all component products.
  logic signed [P2-1:0] mm2 [3];
  logic signed [P2-1:0] cra2 [3];
  logic signed [P2-1:0] crb2 [3];
  logic signed [P2-1:0] ap2 [3];
  logic signed [P2-1:0] bm2 [3];

  for (genvar i = 0; i < 3; i++) begin : g_prod
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        mm2[i]  <= mo1[i] * mo1[i];
        cra2[i] <= pp1[J] * mo1[K];
        crb2[i] <= pp1[K] * mo1[J];
        ap2[i]  <= pp1[i] * mo1[i];
        bm2[i]  <= pm1[i] * mo1[i];
      end
    end
  end

  // Stage 3: |p0|^2, cross product components and both dot products.
  logic [P2-1:0]        dd3;
  logic signed [P2:0]   c3 [3];
  logic signed [P2+1:0] a3;
  logic signed [P2+1:0] b3;

  always_ff @(posedge clk) begin
    if (en) begin
      dd3 <= P2'($unsigned(mm2[0]) + $unsigned(mm2[1]) + $unsigned(mm2[2]));
      for (int i = 0; i < 3; i++) begin
        c3[i] <= (P2+1)'(cra2[i]) - (P2+1)'(crb2[i]);
      end
      a3 <= (P2+2)'(ap2[0]) + (P2+2)'(ap2[1]) + (P2+2)'(ap2[2]);
      b3 <= (P2+2)'(bm2[0]) + (P2+2)'(bm2[1]) + (P2+2)'(bm2[2]);
    end
  end

  // Stage 4: cross magnitudes, alpha numerator and denominator.
  logic [P2-1:0]        cabs4 [3];
  logic signed [P2+2:0] num4;
  logic signed [P2+2:0] den4;
  logic [P2-1:0]        dd4;
  logic                 degmo4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cabs4[i] <= c3[i][P2] ? P2'(-c3[i]) : P2'(c3[i]);
      end
      num4   <= (P2+3)'(a3) - (P2+3)'(b3);
      den4   <= (P2+3)'(a3) + (P2+3)'(b3);
      dd4    <= dd3;
      degmo4 <= (dd3 == '0);
    end
  end

  // Stage 5: partial products of the squared cross magnitudes; alpha signs.
  logic [P2-1:0]  hh5 [3];
  logic [P2-1:0]  hl5 [3];
  logic [P2-1:0]  ll5 [3];
  logic [P2+2:0]  nabs5;
  logic [P2+2:0]  dabs5;
  logic [P2-1:0]  dd5;
  apc_flags_t     fl5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh5[i] <= cabs4[i][P2-1:MB] * cabs4[i][P2-1:MB];
        hl5[i] <= cabs4[i][P2-1:MB] * cabs4[i][MB-1:0];
        ll5[i] <= cabs4[i][MB-1:0] * cabs4[i][MB-1:0];
      end
      nabs5       <= num4[P2+2] ? $unsigned(-num4) : $unsigned(num4);
      dabs5       <= den4[P2+2] ? $unsigned(-den4) : $unsigned(den4);
      dd5         <= dd4;
      fl5.neg     <= num4[P2+2] ^ den4[P2+2];
      fl5.ovf     <= 1'b0;
      fl5.deg_mo  <= degmo4;
      fl5.deg_den <= (den4 == '0);
    end
  end

  // Stage 6: squared cross magnitudes; rounded alpha dividend and divisor.
  logic [P4-1:0]  sq6 [3];
  logic [NA-1:0]  n6;
  logic [DWA-1:0] d2_6;
  logic [P2-1:0]  dd6;
  apc_flags_t     fl6;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= {hh5[i], {P2{1'b0}}}
                + ({{P2{1'b0}}, hl5[i]} << (MB + 1))
                + {{P2{1'b0}}, ll5[i]};
      end
      n6   <= ({{(F+1){1'b0}}, nabs5} << (F + 1)) + NA'(dabs5);
      d2_6 <= {dabs5, 1'b0};
      dd6  <= dd5;
      fl6  <= fl5;
    end
  end

  // Stage 7: |p+ x p0|^2 and the alpha range check ahead of the divider.
  logic [P4-1:0]  nn7;
  logic [DWA-1:0] rema7;
  logic [QA-1:0]  lowa7;
  logic [DWA-1:0] d2_7;
  logic [P2-1:0]  dd7;
  apc_flags_t     fl7;
  logic [DWA-1:0] ntop6;
  logic           ovf6;

  assign ntop6 = DWA'(n6[NA-1:QA]);
  assign ovf6  = (ntop6 >= d2_6);

  always_ff @(posedge clk) begin
    if (en) begin
      nn7         <= sq6[0] + sq6[1] + sq6[2];
      rema7       <= ovf6 ? '0 : ntop6;
      lowa7       <= n6[QA-1:0];
      d2_7        <= d2_6;
      dd7         <= dd6;
      fl7.neg     <= fl6.neg;
      fl7.ovf     <= ovf6;
      fl7.deg_mo  <= fl6.deg_mo;
      fl7.deg_den <= fl6.deg_den;
    end
  end

  // Alpha quotient.
  logic           va;
  logic [QA-1:0]  qa;
  logic [TWA-1:0] taga;
  logic [P4-1:0]  nna;
  logic [P2-1:0]  dda;
  apc_flags_t     fla;

  apc_div #(.DW(DWA), .QW(QA), .TW(TWA)) u_div_alpha (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v[7]),
    .rem_in    (rema7),
    .low_in    (lowa7),
    .div_in    (d2_7),
    .tag_in    ({nn7, dd7, fl7}),
    .out_valid (va),
    .quot      (qa),
    .tag_out   (taga)
  );

  assign {nna, dda, fla} = taga;

  // Squared transverse momentum quotient.
  logic           vp;
  logic [P2-1:0]  qp;
  logic [TWP-1:0] tagp;

  apc_div #(.DW(P2), .QW(P2), .TW(TWP)) u_div_pt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (va),
    .rem_in    (nna[P4-1:P2]),
    .low_in    (nna[P2-1:0]),
    .div_in    (dda),
    .tag_in    ({qa, fla}),
    .out_valid (vp),
    .quot      (qp),
    .tag_out   (tagp)
  );

  // Transverse momentum root.
  logic           vs;
  logic [MB-1:0]  pts;
  logic [TWP-1:0] tags;
  logic [QA-1:0]  qas;
  apc_flags_t     fls;

  apc_sqrt #(.RW(MB), .TW(TWP)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vp),
    .rad_in    (qp),
    .tag_in    (tagp),
    .out_valid (vs),
    .root      (pts),
    .tag_out   (tags)
  );

  assign {qas, fls} = tags;

  // Alpha clamping and the degenerate cases.
  localparam logic [QA-1:0] Lim = QA'(1) << (F + 1);

  logic          sat_c;
  logic [AW-1:0] alpha_c;
  logic [MB-1:0] pt_c;

  always_comb begin
    sat_c   = 1'b0;
    alpha_c = '0;
    pt_c    = pts;
    if (fls.deg_mo) begin
      pt_c = '0;
    end else if (!fls.deg_den) begin
      if (!fls.neg) begin
        sat_c   = fls.ovf || qas[QA-1];
        alpha_c = sat_c ? (Lim - QA'(1)) : qas;
      end else begin
        sat_c   = fls.ovf || (qas > Lim);
        alpha_c = sat_c ? -Lim : -qas;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.transverse_momentum <= pt_c;
      res.asymmetry           <= alpha_c;
      res.asymmetry_saturated <= sat_c;
      res.degenerate          <= fls.deg_mo || fls.deg_den;
    end
  end

`ifndef ASSERT_OFF
  // A clamped alpha only comes from a well-defined candidate.
  a_sat_not_degen: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.asymmetry_saturated |-> !res.degenerate)
    else $error("saturated alpha on a degenerate candidate");

  // A clamped alpha sits exactly at one end of the range.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.asymmetry_saturated |->
      (res.asymmetry == $signed(AW'(Lim - QA'(1)))) || (res.asymmetry == $signed(-Lim)))
    else $error("saturated alpha not at a range limit");

  // While the pipeline holds, no valid bit moves.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v))
    else $error("front pipeline moved during a hold");
`endif

endmodule

>>> hdl/apc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; the caller guarantees the starting remainder is below the divisor.
module apc_div #(
  parameter int DW = 48,
  parameter int QW = 48,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [DW-1:0] div_in,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [TW-1:0] tag_out
);

  logic          vld [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] low [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [TW-1:0] tg  [QW+1];

  assign vld[0] = in_valid;
  assign rem[0] = rem_in;
  assign low[0] = low_in;
  assign quo[0] = '0;
  assign dv[0]  = div_in;
  assign tg[0]  = tag_in;

  // Each stage brings down one numerator bit and tries a subtraction.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;

    assign r2   = {rem[s], low[s][QW-1]};
    assign diff = r2 - {1'b0, dv[s]};
    assign ge   = (r2 >= {1'b0, dv[s]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? diff[DW-1:0] : r2[DW-1:0];
        low[s+1] <= {low[s][QW-2:0], 1'b0};
        quo[s+1] <= {quo[s][QW-2:0], ge};
        dv[s+1]  <= dv[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quot      = quo[QW];
  assign tag_out   = tg[QW];

endmodule

>>> hdl/apc_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per register stage.
// Standalone; gives floor(sqrt(rad_in)).
module apc_sqrt #(
  parameter int RW = 24,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad_in,
  input  logic [TW-1:0]   tag_in,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [TW-1:0]   tag_out
);

  logic            vld [RW+1];
  logic [RW+1:0]   rem [RW+1];
  logic [RW-1:0]   rt  [RW+1];
  logic [2*RW-1:0] rad [RW+1];
  logic [TW-1:0]   tg  [RW+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rad[0] = rad_in;
  assign tg[0]  = tag_in;

  // Each stage brings down two radicand bits and tests the next root bit.
  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+3:0] r4;
    logic [RW+3:0] t;
    logic [RW+3:0] diff;
    logic          ge;

    assign r4   = {rem[s], rad[s][2*RW-1:2*RW-2]};
    assign t    = {2'b00, rt[s], 2'b01};
    assign diff = r4 - t;
    assign ge   = (r4 >= t);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? diff[RW+1:0] : r4[RW+1:0];
        rt[s+1]  <= {rt[s][RW-2:0], ge};
        rad[s+1] <= {rad[s][2*RW-3:0], 2'b00};
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];
  assign tag_out   = tg[RW];

endmodule

>>> tb/armenteros_podolanski_calc_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the Armenteros-Podolanski calculator.
// Depends on apc_pkg, apc_cand_if, apc_res_if, apc_div, apc_sqrt and armenteros_podolanski_calc.
module armenteros_podolanski_calc_tb;

  localparam int MB = 24;
  localparam int AF = 14;
  localparam int LATENCY = 3 * MB + AF + 10;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 750;

  typedef logic signed [MB-1:0] mom_t;

  typedef struct {
    mom_t mo [3];
    mom_t fa [3];
    mom_t fb [3];
    logic first_pos;
  } candidate_t;

  typedef struct {
    logic [MB-1:0]        pt;
    logic signed [AF+1:0] alpha;
    logic                 sat;
    logic                 degen;
  } ap_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  apc_cand_if #(.MOMENTUM_BITS(MB)) cand ();
  apc_res_if #(.MOMENTUM_BITS(MB), .ALPHA_FRAC_BITS(AF)) res ();

  armenteros_podolanski_calc #(.MOMENTUM_BITS(MB), .ALPHA_FRAC_BITS(AF)) dut (
    .clk(clk), .rst(rst), .cand(cand), .res(res)
  );

  candidate_t pending_cands[$];
  ap_result_t expected_results[$];
  int errors = 0;
  int accepted = 0;
  int offered = 0;
  int received = 0;
  int degenerate_seen = 0;
  int saturated_seen = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit stimulus_done = 1'b0;
  int hold_off = 0;
  bit hold_done = 1'b0;
  bit drain_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Reset is held from the start and released on a falling edge.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Integer square root, floor.
  function automatic logic [127:0] int_sqrt(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] b;
    r = 0;
    b = 128'd1 << 126;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Predicts transverse momentum and alpha of one candidate in wide integers.
  function automatic ap_result_t predict_ap(input candidate_t c);
    ap_result_t r;
    logic signed [127:0] pp [3];
    logic signed [127:0] pm [3];
    logic signed [127:0] mo [3];
    logic signed [127:0] dd, nn, cr, a, b, num, den;
    logic [127:0] q, n, d;
    logic neg;
    int j, k;
    for (int i = 0; i < 3; i++) begin
      mo[i] = c.mo[i];
      pp[i] = c.first_pos ? c.fa[i] : c.fb[i];
      pm[i] = c.first_pos ? c.fb[i] : c.fa[i];
    end
    r.pt = 0;
    r.alpha = 0;
    r.sat = 0;
    r.degen = 0;
    dd = mo[0] * mo[0] + mo[1] * mo[1] + mo[2] * mo[2];
    if (dd == 0) begin
      r.degen = 1;
      return r;
    end
    nn = 0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      cr = pp[j] * mo[k] - pp[k] * mo[j];
      nn = nn + cr * cr;
    end
    q = int_sqrt(nn / dd);
    r.pt = (q > (2 ** MB - 1)) ? {MB{1'b1}} : q[MB-1:0];
    a = pp[0] * mo[0] + pp[1] * mo[1] + pp[2] * mo[2];
    b = pm[0] * mo[0] + pm[1] * mo[1] + pm[2] * mo[2];
    num = a - b;
    den = a + b;
    if (den == 0) begin
      r.degen = 1;
      return r;
    end
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = ((n << (AF + 1)) + d) / (d << 1);
    if (!neg) begin
      if (q > (2 ** (AF + 1) - 1)) begin
        q = 2 ** (AF + 1) - 1;
        r.sat = 1;
      end
      r.alpha = q[AF+1:0];
    end else begin
      if (q > 2 ** (AF + 1)) begin
        q = 2 ** (AF + 1);
        r.sat = 1;
      end
      r.alpha = -q[AF+1:0];
    end
    return r;
  endfunction

  function automatic mom_t rand_mom(input int mode);
    case (mode)
      0: return mom_t'($urandom);
      1: return mom_t'($urandom_range(0, 200) - 100);
      2: return mom_t'($urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
      default: return mom_t'($urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  // Physical-looking decay: the mother is mostly the sum of the daughters.
  function automatic candidate_t random_candidate();
    candidate_t c;
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      c.fa[i] = rand_mom(mode);
      c.fb[i] = ($urandom_range(0, 3) == 0) ? rand_mom($urandom_range(0, 3))
                                            : rand_mom(mode);
      c.mo[i] = ($urandom_range(0, 9) == 0) ? rand_mom($urandom_range(0, 3))
                                            : c.fa[i] + c.fb[i];
    end
    if ($urandom_range(0, 19) == 0) c.mo = '{0, 0, 0};
    // Opposite daughters give a zero alpha denominator.
    if ($urandom_range(0, 19) == 0) begin
      for (int i = 0; i < 3; i++) c.fb[i] = -c.fa[i];
    end
    c.first_pos = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic candidate_t make_cand(input mom_t m0, m1, m2, a0, a1, a2,
                                           b0, b1, b2, input logic fp);
    candidate_t c;
    c.mo = '{m0, m1, m2};
    c.fa = '{a0, a1, a2};
    c.fb = '{b0, b1, b2};
    c.first_pos = fp;
    return c;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Fill the stimulus queue: directed corner cases, then random candidates.
  initial begin
    mom_t mx;
    mom_t mn;
    mx = 24'h7fffff;
    mn = 24'h800000;
    pending_cands.push_back(make_cand(0, 0, 0, 5, 6, 7, 1, 2, 3, 1));
    pending_cands.push_back(make_cand(10, 0, 0, 5, 3, 0, 5, -3, 0, 1));
    pending_cands.push_back(make_cand(10, 0, 0, 5, 3, 0, 5, -3, 0, 0));
    pending_cands.push_back(make_cand(10, 0, 0, 5, 3, 0, -5, -3, 0, 1));
    pending_cands.push_back(make_cand(10, 0, 0, 7, 3, 0, -5, -3, 0, 1));
    pending_cands.push_back(make_cand(10, 0, 0, -7, 3, 0, 5, -3, 0, 1));
    pending_cands.push_back(make_cand(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1));
    pending_cands.push_back(make_cand(mn, mn, mn, mn, mn, mn, mn, mn, mn, 0));
    pending_cands.push_back(make_cand(mx, mn, mx, mn, mx, mn, mx, mn, mx, 1));
    pending_cands.push_back(make_cand(1, 0, 0, mn, mx, mn, mx, mn, mx, 0));
    pending_cands.push_back(make_cand(1, 1, 1, mx, mx, mn, 0, 0, 0, 1));
    pending_cands.push_back(make_cand(0, 0, -1, 1, 2, 3, -1, -1, -1, 1));
    pending_cands.push_back(make_cand(3, 4, 0, 3, 0, 0, 0, 4, 0, 0));
    pending_cands.push_back(make_cand(-1, -1, -1, -1, 0, 0, 1, 0, 0, 1));
    pending_cands.push_back(make_cand(mn, 0, 0, 1, mx, 0, 0, mn, 1, 1));
    repeat (RANDOM_ITEMS) pending_cands.push_back(random_candidate());
  end

  // Driver: offers the head of the queue on falling edges and holds it until taken.
  always @(negedge clk) begin
    if (rst) begin
      cand.valid <= 1'b0;
      {cand.mother_px, cand.mother_py, cand.mother_pz} <= '0;
      {cand.first_px, cand.first_py, cand.first_pz} <= '0;
      {cand.second_px, cand.second_py, cand.second_pz} <= '0;
      cand.first_is_positive <= 1'b0;
    end else if (cand.valid && accepted != offered) begin
      // The offered candidate stays unchanged until its transfer.
    end else if (gap_left > 0) begin
      cand.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (accepted == 400 && !drain_done) begin
      // Once, halfway through, let the pipeline drain completely.
      cand.valid <= 1'b0;
      if (expected_results.size() == 0) drain_done <= 1'b1;
    end else if (pending_cands.size() > 0) begin
      cand.mother_px <= pending_cands[0].mo[0];
      cand.mother_py <= pending_cands[0].mo[1];
      cand.mother_pz <= pending_cands[0].mo[2];
      cand.first_px <= pending_cands[0].fa[0];
      cand.first_py <= pending_cands[0].fa[1];
      cand.first_pz <= pending_cands[0].fa[2];
      cand.second_px <= pending_cands[0].fb[0];
      cand.second_py <= pending_cands[0].fb[1];
      cand.second_pz <= pending_cands[0].fb[2];
      cand.first_is_positive <= pending_cands[0].first_pos;
      cand.valid <= 1'b1;
      offered <= offered + 1;
      gap_left <= (accepted > 100 && accepted < 300) ? 0 : gap_len();
    end else begin
      cand.valid <= 1'b0;
      stimulus_done <= 1'b1;
    end
  end

  // Input monitor: each candidate transfer queues its prediction.
  always @(posedge clk) begin
    if (!rst && cand.valid && cand.ready) begin
      expected_results.push_back(predict_ap(pending_cands.pop_front()));
      accepted++;
    end
  end

  // Receiver: random stalls, plus one long hold-off while items keep coming.
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res.ready <= 1'b0;
    end else if (!hold_done && accepted >= 150) begin
      hold_done <= 1'b1;
      hold_off <= 3 * LATENCY;
      res.ready <= 1'b0;
    end else if (accepted > 100 && accepted < 300) begin
      res.ready <= ($urandom_range(0, 9) != 0);
    end else begin
      res.ready <= ($urandom_range(0, 99) < 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    ap_result_t exp_r;
    if (!rst && res.valid && res.ready) begin
      received++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result transfer with none expected: pt=%0d alpha=%0d",
                 $time, res.transverse_momentum, res.asymmetry);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.degen) degenerate_seen++;
        if (exp_r.sat) saturated_seen++;
        if (res.transverse_momentum !== exp_r.pt || res.asymmetry !== exp_r.alpha
            || res.asymmetry_saturated !== exp_r.sat || res.degenerate !== exp_r.degen)
        begin
          errors++;
          $display("%0t: expected pt=%0d alpha=%0d sat=%0b deg=%0b", $time,
                   exp_r.pt, exp_r.alpha, exp_r.sat, exp_r.degen);
          $display("%0t: actual   pt=%0d alpha=%0d sat=%0b deg=%0b", $time,
                   res.transverse_momentum, res.asymmetry,
                   res.asymmetry_saturated, res.degenerate);
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((cand.valid && cand.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("armenteros_podolanski_calc: mismatch");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stimulus_done);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    $display("Sent %0d candidates, checked %0d results (%0d degenerate, %0d saturated).",
             accepted, received, degenerate_seen, saturated_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("armenteros_podolanski_calc: match");
    end else begin
      $display("armenteros_podolanski_calc: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/apc_pkg.sv
hdl/apc_cand_if.sv
hdl/apc_res_if.sv
hdl/apc_div.sv
hdl/apc_sqrt.sv
hdl/armenteros_podolanski_calc.sv
tb/armenteros_podolanski_calc_tb.sv
